[design/centreline_regression_slope_top_assert.svh]
// Assertion macros for the checker file of this block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CENTRELINE_REGRESSION_SLOPE_TOP_ASSERT_SVH
`define CENTRELINE_REGRESSION_SLOPE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CRS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/crs_pkg.sv]
package crs_pkg;

    // Input and output field widths
    localparam int ROW_W   = 7;
    localparam int COL_W   = 8;
    localparam int SLOPE_W = 16;
    localparam int CNT_W   = 8;

    // Packing of the stream words
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 24;
    localparam int ROW_LSB       = 0;
    localparam int CENTRE_LSB    = ROW_LSB + ROW_W;
    localparam int BELOW_LSB     = CENTRE_LSB + COL_W;
    localparam int BLACK_BIT     = BELOW_LSB + COL_W;
    localparam int SLOPE_LSB     = 0;
    localparam int ROWS_USED_LSB = SLOPE_LSB + SLOPE_W;

    // Accumulator widths
    localparam int SX_W  = 15;
    localparam int SY_W  = 15;
    localparam int SXX_W = 22;
    localparam int SXY_W = 23;

    // Shared unit widths
    localparam int MUL_W   = 16;
    localparam int ACC_W   = 27;
    localparam int DIV_W   = 22;
    localparam int REM_W   = 23;
    localparam int DQ_W    = 15;
    localparam int STEP_W  = 4;
    localparam int Q_FRAC  = 8;
    localparam int UP_SPLIT = DQ_W - Q_FRAC;

    // Block constants
    localparam int IMAGE_WIDTH      = 188;
    localparam int MAX_ROWS         = 128;
    localparam int MIN_FIT_ROWS     = 5;
    localparam int JUMP_LIMIT_RESET = IMAGE_WIDTH / 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_ENABLE = 1'b0,
        CFG_JUMP_LIMIT   = 1'b1
    } crs_cfg_idx_t;

    // Request to the multiply-accumulate half of the shared unit
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [MUL_W-1:0]        mul_a;
        logic [MUL_W-1:0]        mul_b;
        logic                    sub;
    } crs_mac_req_t;

    // Request to the restoring divide step of the shared unit
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             bit_in;
        logic [DIV_W-1:0] divisor;
    } crs_div_req_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q_bit;
    } crs_div_rsp_t;

endpackage

[design/crs_unit.sv]
module crs_unit (
    input  crs_pkg::crs_mac_req_t          mac_req,
    output logic signed [crs_pkg::ACC_W-1:0] mac_out,
    input  crs_pkg::crs_div_req_t          div_req,
    output crs_pkg::crs_div_rsp_t          div_rsp
);
    import crs_pkg::*;

    logic [2*MUL_W-1:0]      product;
    logic signed [ACC_W-1:0] prod_s;
    logic [REM_W:0]          shifted;
    logic [REM_W+1:0]        diff;

    // Multiply and add or subtract into the running value
    always_comb
    begin
        product = mac_req.mul_a * mac_req.mul_b;
        prod_s  = $signed(product[ACC_W-1:0]);
        if (mac_req.sub)
        begin
            mac_out = mac_req.acc - prod_s;
        end
        else
        begin
            mac_out = mac_req.acc + prod_s;
        end
    end

    // Shift in one dividend bit, compare and subtract
    always_comb
    begin
        shifted       = {div_req.rem, div_req.bit_in};
        diff          = {1'b0, shifted} - (REM_W + 2)'(div_req.divisor);
        div_rsp.q_bit = !diff[REM_W+1];
        if (div_rsp.q_bit)
        begin
            div_rsp.rem = diff[REM_W-1:0];
        end
        else
        begin
            div_rsp.rem = shifted[REM_W-1:0];
        end
    end

endmodule

[design/centreline_regression_slope_top.sv]
// Center-line slope fit over the rows of one frame.
// Input stream: one request per row. s_tdata carries row, centre, centre_below
// and on_black; s_tlast marks the final row of the frame. Configuration writes
// (check_enable, jump_limit) go through cfg_we/cfg_index/cfg_data; the user must
// make them only while idle, the block itself does not enforce it. Each row is
// accepted and, if it counts, its row and centre added, then it passes twice
// through the shared multiply-accumulate unit for row*row and row*centre.
// s_tready is high only between rows. On the last row, a frame with five rows
// or fewer gives a held result. Otherwise the shared unit runs two 15-step mean
// divisions, seven multiply-accumulate steps and up to 15 steps of the slope
// division before the result appears.
// Output stream: m_tdata carries slope (Q8.8) and rows_used, m_tuser is held.
// The result sits in an output register; while the receiver stalls the next
// frame's rows are still taken, and only the next frame end waits for it.
// Reset clears all sums, the previous slope and the output, and restores
// check_enable to 1 and jump_limit to a third of the image width.
module centreline_regression_slope_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row [6:0], centre [14:7], centre_below [22:15], on_black [23]
    input  logic [crs_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slope [15:0], rows_used [23:16]
    output logic [crs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // held [0]
    output logic                             m_tuser
);
    import crs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_PR, S_DX, S_DY,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_DSET, S_DIV, S_EMIT
    } state_t;

    state_t                  state_reg;
    logic                    check_en_reg;
    logic [COL_W-1:0]        jump_limit_reg;
    logic [SX_W-1:0]         sx_reg;
    logic [SY_W-1:0]         sy_reg;
    logic [SXX_W-1:0]        sxx_reg;
    logic [SXY_W-1:0]        sxy_reg;
    logic [CNT_W-1:0]        n_reg;
    logic                    stopped_reg;
    logic [SLOPE_W-1:0]      prev_slope_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        centre_reg;
    logic                    take_reg;
    logic                    last_reg;
    logic [ROW_W-1:0]        ax_reg;
    logic [COL_W-1:0]        ay_reg;
    logic [SX_W-1:0]         t_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] up_reg;
    logic [DIV_W-1:0]        down_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DQ_W-1:0]         dq_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    neg_reg;
    logic [SLOPE_W-1:0]      res_slope_reg;
    logic                    held_reg;
    logic                    m_tvalid_reg;
    logic [SLOPE_W-1:0]      m_slope_reg;
    logic [CNT_W-1:0]        m_rows_reg;
    logic                    m_held_reg;

    logic [ROW_W-1:0]        row_in;
    logic [COL_W-1:0]        centre_in;
    logic [COL_W-1:0]        below_in;
    logic                    black_in;
    logic [COL_W-1:0]        jump;
    logic                    stop_now;
    logic                    take;
    logic                    accept;
    logic [DQ_W-1:0]         dq_shift;
    logic [ACC_W-1:0]        up_mag;
    logic [SLOPE_W-1:0]      q_ext;
    logic [SLOPE_W-1:0]      q_signed;
    logic                    div_last;

    crs_mac_req_t            mac_req;
    logic signed [ACC_W-1:0] mac_out;
    crs_div_req_t            div_req;
    crs_div_rsp_t            div_rsp;

    crs_unit u_unit (
        .mac_req (mac_req),
        .mac_out (mac_out),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Unpack the row request and decide whether it counts
    always_comb
    begin
        row_in    = s_tdata[ROW_LSB +: ROW_W];
        centre_in = s_tdata[CENTRE_LSB +: COL_W];
        below_in  = s_tdata[BELOW_LSB +: COL_W];
        black_in  = s_tdata[BLACK_BIT];
        jump      = (centre_in > below_in) ? (centre_in - below_in) : (below_in - centre_in);
        stop_now  = stopped_reg || (check_en_reg && (black_in || (jump > jump_limit_reg)));
        take      = !stop_now && (n_reg < CNT_W'(MAX_ROWS));
        accept    = s_tvalid && s_tready;
    end

    // Derived values for the divide and sign steps
    always_comb
    begin
        dq_shift = {dq_reg[DQ_W-2:0], div_rsp.q_bit};
        div_last = (step_reg == STEP_W'(DQ_W - 1));
        up_mag   = up_reg[ACC_W-1] ? ACC_W'(-up_reg) : ACC_W'(up_reg);
        q_ext    = {1'b0, dq_shift};
        q_signed = neg_reg ? (SLOPE_W'(0) - q_ext) : q_ext;
    end

    // Steer the shared unit for the current step
    always_comb
    begin
        mac_req.acc   = '0;
        mac_req.mul_a = '0;
        mac_req.mul_b = '0;
        mac_req.sub   = 1'b0;
        div_req.rem     = rem_reg;
        div_req.bit_in  = dq_reg[DQ_W-1];
        div_req.divisor = DIV_W'(n_reg);
        case (state_reg)
            S_SQ:
            begin
                mac_req.acc   = ACC_W'(sxx_reg);
                mac_req.mul_a = MUL_W'(row_reg);
                mac_req.mul_b = MUL_W'(row_reg);
            end
            S_PR:
            begin
                mac_req.acc   = ACC_W'(sxy_reg);
                mac_req.mul_a = MUL_W'(row_reg);
                mac_req.mul_b = MUL_W'(centre_reg);
            end
            S_M1:
            begin
                mac_req.acc   = ACC_W'(sxy_reg);
                mac_req.mul_a = MUL_W'(ax_reg);
                mac_req.mul_b = MUL_W'(sy_reg);
                mac_req.sub   = 1'b1;
            end
            S_M2:
            begin
                mac_req.acc   = acc_reg;
                mac_req.mul_a = MUL_W'(ay_reg);
                mac_req.mul_b = MUL_W'(sx_reg);
                mac_req.sub   = 1'b1;
            end
            S_M3:
            begin
                mac_req.mul_a = MUL_W'(n_reg);
                mac_req.mul_b = MUL_W'(ax_reg);
            end
            S_M4:
            begin
                mac_req.acc   = acc_reg;
                mac_req.mul_a = MUL_W'(t_reg);
                mac_req.mul_b = MUL_W'(ay_reg);
            end
            S_M5:
            begin
                mac_req.acc   = ACC_W'(sxx_reg);
                mac_req.mul_a = MUL_W'(ax_reg);
                mac_req.mul_b = MUL_W'(sx_reg);
                mac_req.sub   = 1'b1;
            end
            S_M6:
            begin
                mac_req.acc   = acc_reg;
                mac_req.mul_a = MUL_W'(ax_reg);
                mac_req.mul_b = MUL_W'(sx_reg);
                mac_req.sub   = 1'b1;
            end
            S_M7:
            begin
                mac_req.acc   = acc_reg;
                mac_req.mul_a = MUL_W'(t_reg);
                mac_req.mul_b = MUL_W'(ax_reg);
            end
            S_DIV:
            begin
                div_req.divisor = down_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, sums and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            check_en_reg   <= 1'b1;
            jump_limit_reg <= COL_W'(JUMP_LIMIT_RESET);
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxx_reg        <= '0;
            sxy_reg        <= '0;
            n_reg          <= '0;
            stopped_reg    <= 1'b0;
            prev_slope_reg <= '0;
            row_reg        <= '0;
            centre_reg     <= '0;
            take_reg       <= 1'b0;
            last_reg       <= 1'b0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            t_reg          <= '0;
            acc_reg        <= '0;
            up_reg         <= '0;
            down_reg       <= '0;
            rem_reg        <= '0;
            dq_reg         <= '0;
            step_reg       <= '0;
            neg_reg        <= 1'b0;
            res_slope_reg  <= '0;
            held_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_slope_reg    <= '0;
            m_rows_reg     <= '0;
            m_held_reg     <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_we)
            begin
                case (crs_cfg_idx_t'(cfg_index))
                    CFG_CHECK_ENABLE: check_en_reg   <= cfg_data[0];
                    CFG_JUMP_LIMIT:   jump_limit_reg <= cfg_data[COL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Drop the result once the receiver takes it
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        row_reg     <= row_in;
                        centre_reg  <= centre_in;
                        last_reg    <= s_tlast;
                        take_reg    <= take;
                        stopped_reg <= stop_now;
                        if (take)
                        begin
                            sx_reg <= sx_reg + SX_W'(row_in);
                            sy_reg <= sy_reg + SY_W'(centre_in);
                            n_reg  <= n_reg + CNT_W'(1);
                        end
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (take_reg)
                    begin
                        sxx_reg <= mac_out[SXX_W-1:0];
                    end
                    state_reg <= S_PR;
                end
                S_PR:
                begin
                    if (take_reg)
                    begin
                        sxy_reg <= mac_out[SXY_W-1:0];
                    end
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (n_reg > CNT_W'(MIN_FIT_ROWS))
                    begin
                        held_reg  <= 1'b0;
                        rem_reg   <= '0;
                        dq_reg    <= DQ_W'(sx_reg);
                        step_reg  <= '0;
                        state_reg <= S_DX;
                    end
                    else
                    begin
                        held_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_DX:
                begin
                    if (div_last)
                    begin
                        ax_reg    <= dq_shift[ROW_W-1:0];
                        rem_reg   <= '0;
                        dq_reg    <= DQ_W'(sy_reg);
                        step_reg  <= '0;
                        state_reg <= S_DY;
                    end
                    else
                    begin
                        rem_reg  <= div_rsp.rem;
                        dq_reg   <= dq_shift;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_DY:
                begin
                    rem_reg  <= div_rsp.rem;
                    dq_reg   <= dq_shift;
                    step_reg <= step_reg + STEP_W'(1);
                    if (div_last)
                    begin
                        ay_reg    <= dq_shift[COL_W-1:0];
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    acc_reg   <= mac_out;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= mac_out;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    t_reg     <= mac_out[SX_W-1:0];
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    up_reg    <= mac_out;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    acc_reg   <= mac_out;
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    acc_reg   <= mac_out;
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    down_reg  <= mac_out[DIV_W-1:0];
                    state_reg <= S_DSET;
                end
                S_DSET:
                begin
                    neg_reg <= up_reg[ACC_W-1];
                    if (down_reg == '0)
                    begin
                        res_slope_reg <= '0;
                        state_reg     <= S_EMIT;
                    end
                    else if (DIV_W'(up_mag[ACC_W-1:UP_SPLIT]) >= down_reg)
                    begin
                        // Quotient reaches 2^15: clamp
                        res_slope_reg <= up_reg[ACC_W-1] ? {1'b1, (SLOPE_W - 1)'(0)}
                                                         : {1'b0, {(SLOPE_W - 1){1'b1}}};
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        rem_reg   <= REM_W'(up_mag[ACC_W-1:UP_SPLIT]);
                        dq_reg    <= {up_mag[UP_SPLIT-1:0], Q_FRAC'(0)};
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= div_rsp.rem;
                    dq_reg   <= dq_shift;
                    step_reg <= step_reg + STEP_W'(1);
                    if (div_last)
                    begin
                        res_slope_reg <= q_signed;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Load the result when the output register is free, then clear the frame
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_held_reg   <= held_reg;
                        m_rows_reg   <= n_reg;
                        if (held_reg)
                        begin
                            m_slope_reg <= prev_slope_reg;
                        end
                        else
                        begin
                            m_slope_reg    <= res_slope_reg;
                            prev_slope_reg <= res_slope_reg;
                        end
                        sx_reg      <= '0;
                        sy_reg      <= '0;
                        sxx_reg     <= '0;
                        sxy_reg     <= '0;
                        n_reg       <= '0;
                        stopped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_rows_reg, m_slope_reg};
    assign m_tuser  = m_held_reg;

endmodule

[design/crs_checker.sv]
module crs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [crs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import crs_pkg::*;

    `include "centreline_regression_slope_top_assert.svh"

    logic [CNT_W-1:0] rows_used;

    assign rows_used = m_tdata[ROWS_USED_LSB +: CNT_W];

    // A row keeps the sequencer busy for the cycles after it is taken
    `CRS_ASSERT_NEXT(a_busy_after_row, s_tvalid && s_tready, !s_tready, "ready right after a row")

    // A stalled result holds
    `CRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A held slope comes only from a short frame
    `CRS_ASSERT_IMPLY(a_held_short, m_tvalid && m_tuser,
                      rows_used <= CNT_W'(MIN_FIT_ROWS), "held slope with enough rows")

    // A fitted slope needs enough rows and never more than the cap
    `CRS_ASSERT_IMPLY(a_fit_rows, m_tvalid && !m_tuser,
                      (rows_used > CNT_W'(MIN_FIT_ROWS)) && (rows_used <= CNT_W'(MAX_ROWS)),
                      "fitted slope with bad row count")

endmodule

bind centreline_regression_slope_top crs_checker u_crs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/tb_centreline_regression_slope_top.sv]
`timescale 1ns / 1ps

module tb_centreline_regression_slope_top;
    import crs_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 85;

    // One row request as the sender sees it
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] centre;
        logic [COL_W-1:0] centre_below;
        logic             on_black;
        logic             last;
    } row_req_t;

    // One fitted slope result
    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic                      held;
        logic [CNT_W-1:0]          rows_used;
    } slope_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    centreline_regression_slope_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    row_req_t   row_q[$];
    slope_res_t slope_q[$];
    int         mismatches = 0;
    int         cycle_count = 0;

    // Shadow of the configuration registers
    logic             chk_en   = 1'b1;
    logic [7:0]       max_jump = COL_W'(JUMP_LIMIT_RESET);

    // Shadow of the frame accumulators
    logic [SX_W-1:0]    acc_x  = '0;
    logic [SY_W-1:0]    acc_y  = '0;
    logic [SXX_W-1:0]   acc_xx = '0;
    logic [SXY_W-1:0]   acc_xy = '0;
    logic [CNT_W-1:0]   n_rows = '0;
    logic               frame_stopped = 1'b0;
    logic [SLOPE_W-1:0] last_slope = '0;

    // Add one row to the frame sums; on the last row, queue the fitted slope
    task automatic fit_row(input row_req_t r);
        int unsigned jump;
        longint n, sx, sy, sxx, sxy, ax, ay, up, down, q;
        slope_res_t res;
        jump = (r.centre > r.centre_below) ? 32'(r.centre - r.centre_below)
                                           : 32'(r.centre_below - r.centre);
        if (!frame_stopped && chk_en && (r.on_black || jump > 32'(max_jump)))
            frame_stopped = 1'b1;
        if (!frame_stopped && n_rows < CNT_W'(MAX_ROWS))
        begin
            acc_x  = acc_x + SX_W'(r.row);
            acc_y  = acc_y + SY_W'(r.centre);
            acc_xx = acc_xx + SXX_W'(r.row) * SXX_W'(r.row);
            acc_xy = acc_xy + SXY_W'(r.row) * SXY_W'(r.centre);
            n_rows = n_rows + CNT_W'(1);
        end
        if (r.last)
        begin
            if (n_rows <= CNT_W'(MIN_FIT_ROWS))
            begin
                res.held = 1'b1;
            end
            else
            begin
                n    = longint'(n_rows);
                sx   = longint'(acc_x);
                sy   = longint'(acc_y);
                sxx  = longint'(acc_xx);
                sxy  = longint'(acc_xy);
                ax   = sx / n;
                ay   = sy / n;
                up   = sxy - ax * sy - ay * sx + n * ax * ay;
                down = sxx - 2 * ax * sx + n * ax * ax;
                if (down == 0)
                    q = 0;
                else
                    q = (up * 256) / down;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                last_slope = q[SLOPE_W-1:0];
                res.held = 1'b0;
            end
            res.slope     = last_slope;
            res.rows_used = n_rows;
            slope_q.push_back(res);
            acc_x  = '0;
            acc_y  = '0;
            acc_xx = '0;
            acc_xy = '0;
            n_rows = '0;
            frame_stopped = 1'b0;
        end
    endtask

    // Sender: bursts of requests separated by random gaps
    logic req_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;

    always @(negedge clk)
    begin
        row_req_t r;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (gap_left != 0 || row_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                r = row_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {r.on_black, r.centre_below, r.centre, r.row};
                s_tlast  <= r.last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: stall pattern of ready and stalled stretches
    int rx_left = 0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    m_tready <= 1'b1;
                    rx_left  <= $urandom_range(1, 30);
                end
                4:
                begin
                    m_tready <= 1'b1;
                    rx_left  <= $urandom_range(100, 300);
                end
                5, 6, 7:
                begin
                    m_tready <= 1'b0;
                    rx_left  <= $urandom_range(1, 6);
                end
                8:
                begin
                    m_tready <= 1'b0;
                    rx_left  <= $urandom_range(20, 90);
                end
                default:
                begin
                    m_tready <= 1'($urandom_range(0, 1));
                    rx_left  <= 1;
                end
            endcase
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
    end

    // Monitor: track config writes, predict on accepted rows, check results
    always @(posedge clk)
    begin
        slope_res_t got;
        slope_res_t want;
        cycle_count <= cycle_count + 1;
        req_taken   <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CHECK_ENABLE)
                    chk_en = cfg_data[0];
                else if (cfg_index == CFG_JUMP_LIMIT)
                    max_jump = cfg_data;
            end
            if (s_tvalid && s_tready)
                fit_row({s_tdata[ROW_LSB +: ROW_W], s_tdata[CENTRE_LSB +: COL_W],
                         s_tdata[BELOW_LSB +: COL_W], s_tdata[BLACK_BIT], s_tlast});
            if (m_tvalid && m_tready)
            begin
                got.slope     = m_tdata[SLOPE_LSB +: SLOPE_W];
                got.rows_used = m_tdata[ROWS_USED_LSB +: CNT_W];
                got.held      = m_tuser;
                if (slope_q.size() == 0)
                begin
                    $error("unexpected result: slope %0d held %0d rows_used %0d",
                           $signed(got.slope), got.held, got.rows_used);
                    mismatches++;
                end
                else
                begin
                    want = slope_q.pop_front();
                    if (got.slope !== want.slope)
                    begin
                        $error("slope: expected %0d, got %0d",
                               $signed(want.slope), $signed(got.slope));
                        mismatches++;
                    end
                    if (got.held !== want.held)
                    begin
                        $error("held: expected %0d, got %0d", want.held, got.held);
                        mismatches++;
                    end
                    if (got.rows_used !== want.rows_used)
                    begin
                        $error("rows_used: expected %0d, got %0d",
                               want.rows_used, got.rows_used);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic queue_row(input int row, input int centre, input int below,
                             input bit black, input bit last);
        row_req_t r;
        r.row          = ROW_W'(row);
        r.centre       = COL_W'(centre);
        r.centre_below = COL_W'(below);
        r.on_black     = black;
        r.last         = last;
        row_q.push_back(r);
    endtask

    // Well-formed frame: rows walk downward, centre drifts, below is the previous centre
    task automatic queue_track_frame(input int len);
        int r, c, below;
        r = $urandom_range((len > 127) ? 127 : len - 1, 127);
        c = $urandom_range(0, 255);
        below = c;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                c = $urandom_range(0, 255);
            else
                c = c + $urandom_range(0, 8) - 4;
            if (c < 0)
                c = 0;
            if (c > 255)
                c = 255;
            queue_row(r, c, below, $urandom_range(0, 39) == 0, k == len - 1);
            below = c;
            if ($urandom_range(0, 19) != 0 && r > 0)
                r = r - 1;
        end
    endtask

    // Broken frame: every field random
    task automatic queue_noise_frame(input int len);
        for (int k = 0; k < len; k++)
            queue_row($urandom_range(0, 127), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1) == 1, k == len - 1);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic wait_drained();
        while (row_q.size() != 0 || s_tvalid || slope_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input crs_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_config(input bit chk, input int lim);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_CHECK_ENABLE, {7'($urandom_range(0, 127)), chk});
        write_reg(CFG_JUMP_LIMIT, lim[7:0]);
    endtask

    // Stimulus phases
    bit chk_tab[RAND_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    int lim_tab[RAND_PHASES] = '{0, 255, 62, -1, -2, -1, 62};

    initial
    begin
        int count, len, lim;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Reset settings: jump stop at the extremes, a clean fit, black stop,
        // zero denominator
        queue_row(127, 255, 0, 1'b0, 1'b1);
        for (int k = 0; k < 7; k++)
            queue_row(10 - k, 100 + 3 * k, (k == 0) ? 100 : 97 + 3 * k, 1'b0, k == 6);
        queue_row(50, 80, 80, 1'b0, 1'b0);
        queue_row(49, 80, 80, 1'b1, 1'b0);
        queue_row(48, 80, 80, 1'b0, 1'b0);
        queue_row(47, 80, 80, 1'b0, 1'b1);
        for (int k = 0; k < 6; k++)
            queue_row(0, 0, 0, 1'b0, k == 5);

        // Garage mode: both saturation limits, blacks and jumps ignored
        write_config(1'b0, 0);
        for (int k = 0; k < 5; k++)
            queue_row(0, 0, 255, k == 2, 1'b0);
        queue_row(1, 255, 0, 1'b1, 1'b1);
        for (int k = 0; k < 5; k++)
            queue_row(0, 255, 0, 1'b0, 1'b0);
        queue_row(1, 0, 255, 1'b0, 1'b1);

        // Random frames under a sequence of settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (lim_tab[p] == -1)
                lim = $urandom_range(0, 255);
            else if (lim_tab[p] == -2)
                lim = $urandom_range(20, 80);
            else
                lim = lim_tab[p];
            write_config(chk_tab[p], lim);
            if (!chk_tab[p] && lim == 62)
                queue_track_frame(140);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 20);
                if ($urandom_range(0, 9) < 8)
                    queue_track_frame(len);
                else
                    queue_noise_frame(len);
                count += len;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
